[hw/rtl/ffha_pkg.sv]
// ffha_pkg: shared constants, codes and request/result types for the
// first-fit heap allocator. No dependencies.
`default_nettype none
package ffha_pkg;
    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 24;
    localparam int ALIGN_BYTES  = 8;
    localparam int NUM_SEGS     = 16;

    localparam int HDR         = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int HEAP_USE    = (HEAP_BYTES / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int STORE_DEPTH = HEAP_BYTES / ALIGN_BYTES;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int ALIGN_SH    = $clog2(ALIGN_BYTES);
    localparam int POS_W       = $clog2(HEAP_USE + 1);
    localparam int END_W       = POS_W + 1;
    localparam int SIZE_W      = 16;
    localparam int RSZ_W       = 18;
    localparam int SEG_IW      = $clog2(NUM_SEGS);
    localparam int CNT_W       = $clog2(NUM_SEGS + 1);

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_ALLOC = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FREED = 2'd2,
        ST_ERR   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_ALLOC, S_FRD, S_FCHK, S_FSCAN, S_FVAL, S_FINS, S_MLO, S_MHI
    } t_state;

    typedef struct packed {
        logic        req_type;
        logic [16:0] req_size;
        logic [15:0] free_addr;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] addr;
    } t_rsp;

    typedef struct packed {
        logic    load;
        logic    step;
        logic    commit;
        logic    f_latch;
        logic    insert;
        logic    merge_lo;
        logic    merge_hi;
        logic    emit;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic a_zero;
        logic a_fit;
        logic idx_end;
        logic f_bad_addr;
        logic f_bad_end;
        logic scan_stop;
        logic f_reject;
        logic touch_lo;
        logic touch_hi;
    } t_stat;
endpackage
`default_nettype wire

[hw/rtl/first_fit_heap_allocator.sv]
// first_fit_heap_allocator: top level; depends on ffha_pkg, ffha_ctrl, ffha_dp.
// Allocate walks segments in address order until one fits or the table ends (at most NUM_SEGS passed);
//   free reads, checks the end, scans, validates, inserts and merges; errors end at the failing check.
// One request at a time; busy drops in the strobe cycle, where the next can be taken.
// The receiver cannot stall: each result shows for exactly one cycle.
// Synchronous active-low reset restores one free segment spanning the heap.
`default_nettype none
module first_fit_heap_allocator (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire ffha_pkg::t_req i_req,
    output logic                o_done,
    output ffha_pkg::t_rsp      o_rsp
);
    ffha_pkg::t_cmd  cmd;
    ffha_pkg::t_stat stat;

    // controller sequences the table walks
    ffha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath holds the free table and per-block size store
    ffha_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );
endmodule
`default_nettype wire

[hw/rtl/ffha_ram.sv]
// ffha_ram: generic single-port RAM, registered read.
// No dependencies.
`default_nettype none
module ffha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

[hw/rtl/ffha_ctrl.sv]
// ffha_ctrl: request sequencer for the allocator.
// Depends on ffha_pkg.
`default_nettype none
module ffha_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire ffha_pkg::t_stat i_stat,
    output ffha_pkg::t_cmd      o_cmd
);
    ffha_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ffha_pkg::S_IDLE: begin
                if (start) n_state = i_stat.is_free ? ffha_pkg::S_FRD : ffha_pkg::S_ALLOC;
            end
            ffha_pkg::S_ALLOC: begin
                if (i_stat.a_zero || i_stat.idx_end || i_stat.a_fit) n_state = ffha_pkg::S_IDLE;
            end
            ffha_pkg::S_FRD: begin
                n_state = i_stat.f_bad_addr ? ffha_pkg::S_IDLE : ffha_pkg::S_FCHK;
            end
            ffha_pkg::S_FCHK: begin
                n_state = i_stat.f_bad_end ? ffha_pkg::S_IDLE : ffha_pkg::S_FSCAN;
            end
            ffha_pkg::S_FSCAN: begin
                if (i_stat.scan_stop) n_state = ffha_pkg::S_FVAL;
            end
            ffha_pkg::S_FVAL: begin
                n_state = i_stat.f_reject ? ffha_pkg::S_IDLE : ffha_pkg::S_FINS;
            end
            ffha_pkg::S_FINS: n_state = ffha_pkg::S_MLO;
            ffha_pkg::S_MLO:  n_state = ffha_pkg::S_MHI;
            ffha_pkg::S_MHI:  n_state = ffha_pkg::S_IDLE;
            default:          n_state = ffha_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.code = ffha_pkg::ST_NOFIT;
        busy       = (r_state != ffha_pkg::S_IDLE);
        case (r_state)
            ffha_pkg::S_IDLE: begin
                o_cmd.load = start;
            end
            ffha_pkg::S_ALLOC: begin
                if (i_stat.a_zero || i_stat.idx_end) begin
                    o_cmd.emit = 1'b1;
                end else if (i_stat.a_fit) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.emit   = 1'b1;
                    o_cmd.code   = ffha_pkg::ST_ALLOC;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ffha_pkg::S_FRD: begin
                o_cmd.emit   = i_stat.f_bad_addr;
                o_cmd.code   = ffha_pkg::ST_ERR;
            end
            ffha_pkg::S_FCHK: begin
                o_cmd.f_latch = 1'b1;
                o_cmd.emit    = i_stat.f_bad_end;
                o_cmd.code    = ffha_pkg::ST_ERR;
            end
            ffha_pkg::S_FSCAN: begin
                o_cmd.step = !i_stat.scan_stop;
            end
            ffha_pkg::S_FVAL: begin
                o_cmd.emit = i_stat.f_reject;
                o_cmd.code = ffha_pkg::ST_ERR;
            end
            ffha_pkg::S_FINS: begin
                o_cmd.insert = 1'b1;
            end
            ffha_pkg::S_MLO: begin
                o_cmd.merge_lo = i_stat.touch_lo;
            end
            ffha_pkg::S_MHI: begin
                o_cmd.merge_hi = i_stat.touch_hi;
                o_cmd.emit     = 1'b1;
                o_cmd.code     = ffha_pkg::ST_FREED;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end
endmodule
`default_nettype wire

[hw/rtl/ffha_dp.sv]
// ffha_dp: segment table, block size store and result register.
// Depends on ffha_pkg and ffha_ram.
`default_nettype none
module ffha_dp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ffha_pkg::t_req  i_req,
    input  wire ffha_pkg::t_cmd  i_cmd,
    output ffha_pkg::t_stat      o_stat,
    output logic                 o_done,
    output ffha_pkg::t_rsp       o_rsp
);
    localparam int NS = ffha_pkg::NUM_SEGS;

    logic [ffha_pkg::POS_W-1:0]  r_start [NS];
    logic [ffha_pkg::SIZE_W-1:0] r_size  [NS];
    logic [ffha_pkg::CNT_W-1:0]  r_count;
    logic [ffha_pkg::CNT_W-1:0]  r_idx;
    ffha_pkg::t_req              r_req;
    logic [ffha_pkg::SIZE_W-1:0] r_sz;
    logic [ffha_pkg::END_W-1:0]  r_end;
    logic [ffha_pkg::POS_W-1:0]  r_hdr_at;

    logic [ffha_pkg::RSZ_W-1:0]  rnd, need;
    logic [ffha_pkg::SEG_IW-1:0] ix, ixm1, ixp1;
    logic [ffha_pkg::END_W-1:0]  end_cur, end_prev, f_end;
    logic [ffha_pkg::POS_W-1:0]  payload, pay_new, hdr_at;
    logic [ffha_pkg::SIZE_W-1:0] ram_q;
    logic [ffha_pkg::STORE_AW-1:0] ram_a;
    logic                        has_prev, has_cur, has_next;

    assign ix       = r_idx[ffha_pkg::SEG_IW-1:0];
    assign ixm1     = ix - 1'b1;
    assign ixp1     = ix + 1'b1;
    assign has_prev = (r_idx != '0);
    assign has_cur  = (r_idx < r_count);
    assign has_next = ({1'b0, r_idx} + 1'b1) < {1'b0, r_count};

    assign rnd  = (({1'b0, r_req.req_size} + ffha_pkg::RSZ_W'(ffha_pkg::ALIGN_BYTES - 1))
                  >> ffha_pkg::ALIGN_SH) << ffha_pkg::ALIGN_SH;
    assign need = rnd + ffha_pkg::RSZ_W'(ffha_pkg::HDR);
    assign payload = r_start[ix] + ffha_pkg::POS_W'(ffha_pkg::HDR);
    assign pay_new = payload + rnd[ffha_pkg::POS_W-1:0];

    assign end_cur  = ffha_pkg::END_W'(r_start[ix]) + ffha_pkg::END_W'(ffha_pkg::HDR)
                    + ffha_pkg::END_W'(r_size[ix]);
    assign end_prev = ffha_pkg::END_W'(r_start[ixm1]) + ffha_pkg::END_W'(ffha_pkg::HDR)
                    + ffha_pkg::END_W'(r_size[ixm1]);
    assign f_end  = ffha_pkg::END_W'(r_req.free_addr) + ffha_pkg::END_W'(ram_q);
    assign hdr_at = ffha_pkg::POS_W'(r_req.free_addr) - ffha_pkg::POS_W'(ffha_pkg::HDR);

    // store index is the payload offset in alignment units
    assign ram_a = i_cmd.commit
                 ? ffha_pkg::STORE_AW'(payload >> ffha_pkg::ALIGN_SH)
                 : ffha_pkg::STORE_AW'(r_req.free_addr >> ffha_pkg::ALIGN_SH);

    ffha_ram #(.WIDTH(ffha_pkg::SIZE_W), .DEPTH(ffha_pkg::STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_addr  (ram_a),
        .i_wdata (rnd[ffha_pkg::SIZE_W-1:0]),
        .o_rdata (ram_q)
    );

    always_comb begin
        o_stat            = '0;
        o_stat.is_free    = (i_req.req_type == ffha_pkg::REQ_FREE);
        o_stat.a_zero     = (r_req.req_size == '0);
        o_stat.idx_end    = !has_cur;
        o_stat.a_fit      = has_cur && (ffha_pkg::RSZ_W'(r_size[ix]) >= need);
        o_stat.f_bad_addr = (r_req.free_addr < 16'(ffha_pkg::HDR))
                         || (r_req.free_addr[ffha_pkg::ALIGN_SH-1:0] != '0)
                         || (ffha_pkg::END_W'(r_req.free_addr) >= ffha_pkg::END_W'(ffha_pkg::HEAP_USE));
        o_stat.f_bad_end  = f_end > ffha_pkg::END_W'(ffha_pkg::HEAP_USE);
        o_stat.scan_stop  = !has_cur || (r_start[ix] > r_hdr_at);
        o_stat.f_reject   = (has_prev && (end_prev > ffha_pkg::END_W'(r_hdr_at)))
                         || (has_cur && (r_end > ffha_pkg::END_W'(r_start[ix])))
                         || (r_count >= ffha_pkg::CNT_W'(NS));
        o_stat.touch_lo   = has_prev && (end_prev == ffha_pkg::END_W'(r_start[ix]));
        o_stat.touch_hi   = has_next && (end_cur == ffha_pkg::END_W'(r_start[ixp1]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= ffha_pkg::CNT_W'(1);
            r_start[0] <= '0;
            r_size[0]  <= ffha_pkg::SIZE_W'(ffha_pkg::HEAP_USE - ffha_pkg::HDR);
            o_done    <= 1'b0;
        end else begin
            o_done <= i_cmd.emit;
            if (i_cmd.commit) begin
                r_start[ix] <= pay_new;
                r_size[ix]  <= r_size[ix] - ffha_pkg::SIZE_W'(need);
            end
            if (i_cmd.insert) begin
                for (int k = 0; k < NS; k++) begin
                    if (k > int'(r_idx) && k > 0) begin
                        r_start[k] <= r_start[k-1];
                        r_size[k]  <= r_size[k-1];
                    end else if (k == int'(r_idx)) begin
                        r_start[k] <= r_hdr_at;
                        r_size[k]  <= r_sz;
                    end
                end
                r_count <= r_count + 1'b1;
            end
            // merge the entry at idx into the one below, or the one above into the entry at idx; close the gap
            if (i_cmd.merge_lo || i_cmd.merge_hi) begin
                if (i_cmd.merge_lo) begin
                    r_size[ixm1] <= r_size[ixm1] + ffha_pkg::SIZE_W'(ffha_pkg::HDR) + r_size[ix];
                end else begin
                    r_size[ix] <= r_size[ix] + ffha_pkg::SIZE_W'(ffha_pkg::HDR) + r_size[ixp1];
                end
                for (int k = 0; k < NS - 1; k++) begin
                    if ((i_cmd.merge_lo && k >= int'(r_idx))
                        || (i_cmd.merge_hi && k > int'(r_idx))) begin
                        r_start[k] <= r_start[k+1];
                        r_size[k]  <= r_size[k+1];
                    end
                end
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load || i_cmd.f_latch) begin
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.merge_lo) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.f_latch) begin
            r_sz     <= ram_q;
            r_end    <= f_end;
            r_hdr_at <= hdr_at;
        end
        if (i_cmd.emit) begin
            o_rsp.status <= i_cmd.code;
            o_rsp.addr   <= (i_cmd.code == ffha_pkg::ST_ALLOC) ? payload[15:0] : '0;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/ffha_checker.sv]
// ffha_checker: port-level checks of the allocator, bound to the top level.
// Depends on ffha_pkg.
`default_nettype none
module ffha_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           o_done,
    input wire ffha_pkg::t_rsp o_rsp
);
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result while busy");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("request not taken");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("back to back results");
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != ffha_pkg::ST_ALLOC) |-> (o_rsp.addr == '0))
        else $error("nonzero addr");
endmodule

bind first_fit_heap_allocator ffha_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking bench for first_fit_heap_allocator, with a built-in free-list predictor.
// Depends on ffha_pkg and the allocator RTL.
`default_nettype none
module tb;
    localparam int STALL_LIMIT = 4000;  // cycles with no request or result accepted
    localparam int N_RANDOM    = 1830;
    localparam int N_ROWS      = 22;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    ffha_pkg::t_req  i_req = '0;
    logic            o_done;
    ffha_pkg::t_rsp  o_rsp;

    always #5 i_clk = ~i_clk;

    first_fit_heap_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    // ---------------------------------------------------------------
    // Free-list shadow: address-sorted segments, recorded block sizes.
    // ---------------------------------------------------------------
    int unsigned    free_seg_start [ffha_pkg::NUM_SEGS];
    int unsigned    free_seg_size  [ffha_pkg::NUM_SEGS];
    int unsigned    free_seg_cnt;
    int unsigned    blk_size_rec   [ffha_pkg::STORE_DEPTH];
    int unsigned    live_blocks[$];   // payload offsets handed out and not yet freed
    int unsigned    used_offsets[$];  // every offset ever handed out (size recorded)
    ffha_pkg::t_rsp pending_rsp[$];
    int             n_errors = 0;
    int             idle_cnt = 0;

    function automatic ffha_pkg::t_rsp heap_predict(ffha_pkg::t_req r);
        ffha_pkg::t_rsp res;
        int unsigned    rsz, pay, a, sz, blk_end, hdr_at, p, i, k;
        int             j;
        res = '{status: ffha_pkg::ST_NOFIT, addr: '0};
        if (r.req_type == ffha_pkg::REQ_ALLOC) begin
            if (r.req_size == 0) return res;
            rsz = ((r.req_size + ffha_pkg::ALIGN_BYTES - 1) / ffha_pkg::ALIGN_BYTES)
                  * ffha_pkg::ALIGN_BYTES;
            for (i = 0; i < free_seg_cnt; i++) begin
                if (free_seg_size[i] >= rsz + ffha_pkg::HDR) begin
                    pay = free_seg_start[i] + ffha_pkg::HDR;
                    free_seg_start[i] = pay + rsz;
                    free_seg_size[i]  = free_seg_size[i] - rsz - ffha_pkg::HDR;
                    blk_size_rec[pay / ffha_pkg::ALIGN_BYTES] = rsz;
                    live_blocks.push_back(pay);
                    used_offsets.push_back(pay);
                    res.status = ffha_pkg::ST_ALLOC;
                    res.addr   = pay[15:0];
                    return res;
                end
            end
            return res;
        end
        res.status = ffha_pkg::ST_ERR;
        a = r.free_addr;
        if (a < ffha_pkg::HDR || (a % ffha_pkg::ALIGN_BYTES) != 0 || a >= ffha_pkg::HEAP_USE)
            return res;
        sz      = blk_size_rec[a / ffha_pkg::ALIGN_BYTES];
        blk_end = a + sz;
        if (blk_end > ffha_pkg::HEAP_USE) return res;
        hdr_at = a - ffha_pkg::HDR;
        p = 0;
        while (p < free_seg_cnt && free_seg_start[p] <= hdr_at) p++;
        // overlap with a free neighbor on either side (double free lands here)
        if (p > 0 && free_seg_start[p-1] + ffha_pkg::HDR + free_seg_size[p-1] > hdr_at)
            return res;
        if (p < free_seg_cnt && blk_end > free_seg_start[p]) return res;
        // full table rejects even when the merge would have freed a slot
        if (free_seg_cnt >= ffha_pkg::NUM_SEGS) return res;
        for (k = free_seg_cnt; k > p; k--) begin
            free_seg_start[k] = free_seg_start[k-1];
            free_seg_size[k]  = free_seg_size[k-1];
        end
        free_seg_start[p] = hdr_at;
        free_seg_size[p]  = sz;
        free_seg_cnt++;
        // coalesce every touching pair, header counted
        i = 0;
        while (i + 1 < free_seg_cnt) begin
            if (free_seg_start[i] + ffha_pkg::HDR + free_seg_size[i] == free_seg_start[i+1]) begin
                free_seg_size[i] = free_seg_size[i] + ffha_pkg::HDR + free_seg_size[i+1];
                for (k = i + 1; k + 1 < free_seg_cnt; k++) begin
                    free_seg_start[k] = free_seg_start[k+1];
                    free_seg_size[k]  = free_seg_size[k+1];
                end
                free_seg_cnt--;
            end else begin
                i++;
            end
        end
        for (j = 0; j < live_blocks.size(); j++) begin
            if (live_blocks[j] == a) begin
                live_blocks.delete(j);
                break;
            end
        end
        res.status = ffha_pkg::ST_FREED;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Request driver: holds start until the edge where busy is low.
    // ---------------------------------------------------------------
    int sender_idle_pct = 0;

    task automatic issue_request(ffha_pkg::t_req r, bit typed, ffha_pkg::t_rsp typed_rsp);
        ffha_pkg::t_rsp pred;
        start <= 1'b1;
        i_req <= r;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        pred = heap_predict(r);
        pending_rsp.push_back(typed ? typed_rsp : pred);
        // optional gap after the accept; start lowered once in this step
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // ---------------------------------------------------------------
    // Result checker: one strobe per request, compared in order.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result status=%0d addr=%0d",
                         $time, o_rsp.status, o_rsp.addr);
                n_errors++;
            end else begin
                if (o_rsp.status !== pending_rsp[0].status) begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, pending_rsp[0].status, o_rsp.status);
                    n_errors++;
                end
                if (o_rsp.addr !== pending_rsp[0].addr) begin
                    $display("%0t: addr mismatch expected %0d actual %0d",
                             $time, pending_rsp[0].addr, o_rsp.addr);
                    n_errors++;
                end
                void'(pending_rsp.pop_front());
            end
        end
    end

    // Watchdog: counts cycles with neither a request nor a result taken.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Directed rows: expected result typed only where obvious.
    // ---------------------------------------------------------------
    typedef struct {
        logic              rtype;
        int unsigned       size;
        int unsigned       faddr;
        bit                typed;
        ffha_pkg::t_status st;
        int unsigned       addr;
    } t_row;

    t_row directed_rows[N_ROWS] = '{
        '{ffha_pkg::REQ_ALLOC, 0,     0,     1, ffha_pkg::ST_NOFIT, 0},  // zero size
        '{ffha_pkg::REQ_ALLOC, 65536, 0,     1, ffha_pkg::ST_NOFIT, 0},  // largest, no fit
        '{ffha_pkg::REQ_ALLOC, 1,     0,     1, ffha_pkg::ST_ALLOC, 24}, // first block
        '{ffha_pkg::REQ_FREE,  0,     0,     1, ffha_pkg::ST_ERR,   0},  // below header
        '{ffha_pkg::REQ_FREE,  0,     23,    1, ffha_pkg::ST_ERR,   0},
        '{ffha_pkg::REQ_FREE,  0,     25,    1, ffha_pkg::ST_ERR,   0},  // unaligned
        '{ffha_pkg::REQ_FREE,  0,     65535, 1, ffha_pkg::ST_ERR,   0},
        '{ffha_pkg::REQ_FREE,  0,     24,    1, ffha_pkg::ST_FREED, 0},
        '{ffha_pkg::REQ_FREE,  0,     24,    1, ffha_pkg::ST_ERR,   0},  // double free
        '{ffha_pkg::REQ_ALLOC, 65480, 0,     1, ffha_pkg::ST_ALLOC, 24},
        '{ffha_pkg::REQ_ALLOC, 8,     0,     1, ffha_pkg::ST_NOFIT, 0},  // tail too short
        '{ffha_pkg::REQ_FREE,  0,     24,    1, ffha_pkg::ST_FREED, 0},
        '{ffha_pkg::REQ_ALLOC, 65488, 0,     1, ffha_pkg::ST_ALLOC, 24}, // zero-size tail
        '{ffha_pkg::REQ_ALLOC, 1,     0,     1, ffha_pkg::ST_NOFIT, 0},
        '{ffha_pkg::REQ_FREE,  0,     24,    1, ffha_pkg::ST_FREED, 0},
        '{ffha_pkg::REQ_ALLOC, 100,   0,     0, ffha_pkg::ST_ALLOC, 0},
        '{ffha_pkg::REQ_ALLOC, 200,   0,     0, ffha_pkg::ST_ALLOC, 0},
        '{ffha_pkg::REQ_ALLOC, 300,   0,     0, ffha_pkg::ST_ALLOC, 0},
        '{ffha_pkg::REQ_ALLOC, 65536, 0,     1, ffha_pkg::ST_NOFIT, 0},
        '{ffha_pkg::REQ_FREE,  0,     152,   1, ffha_pkg::ST_FREED, 0},  // mid-list hole
        '{ffha_pkg::REQ_ALLOC, 7,     0,     0, ffha_pkg::ST_ALLOC, 0},  // splits the hole
        '{ffha_pkg::REQ_FREE,  0,     24,    1, ffha_pkg::ST_FREED, 0}
    };

    function automatic ffha_pkg::t_req random_request();
        ffha_pkg::t_req r;
        int             pick;
        r = '0;
        r.req_size  = 17'($urandom);
        r.free_addr = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 50 || live_blocks.size() == 0) begin
            r.req_type = ffha_pkg::REQ_ALLOC;
            case ($urandom_range(19))
                0:       r.req_size = 0;
                1:       r.req_size = 17'd65536;
                2:       r.req_size = 17'($urandom_range(1, 65536));
                3, 4:    r.req_size = 17'($urandom_range(1, 8192));
                default: r.req_size = 17'($urandom_range(1, 1024));
            endcase
        end else begin
            r.req_type = ffha_pkg::REQ_FREE;
            if (pick < 85) begin
                r.free_addr = 16'(live_blocks[$urandom_range(live_blocks.size() - 1)]);
            end else if (pick < 93) begin
                r.free_addr = 16'(used_offsets[$urandom_range(used_offsets.size() - 1)]);
            end else begin
                // malformed offset: unaligned or inside the first header
                r.free_addr = (pick < 97) ? (16'($urandom) | 16'd1)
                                          : 16'($urandom_range(0, ffha_pkg::HDR - 1));
            end
        end
        return r;
    endfunction

    initial begin
        ffha_pkg::t_req r;
        ffha_pkg::t_rsp tr;
        int             settle;
        free_seg_cnt      = 1;
        free_seg_start[0] = 0;
        free_seg_size[0]  = ffha_pkg::HEAP_USE - ffha_pkg::HDR;
        foreach (blk_size_rec[k]) blk_size_rec[k] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            r.req_type  = directed_rows[k].rtype;
            r.req_size  = 17'(directed_rows[k].size);
            r.free_addr = 16'(directed_rows[k].faddr);
            tr.status   = directed_rows[k].st;
            tr.addr     = 16'(directed_rows[k].addr);
            issue_request(r, directed_rows[k].typed, tr);
        end

        // four idling phases; a full drain just after the third one begins
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % (N_RANDOM / 4) == 0) begin
                case (n / (N_RANDOM / 4))
                    0:       sender_idle_pct = 0;
                    1:       sender_idle_pct = 68;
                    2:       sender_idle_pct = 0;
                    default: sender_idle_pct = 30;
                endcase
            end
            if (n == N_RANDOM / 2) begin
                start <= 1'b0;
                wait (pending_rsp.size() == 0);
                @(posedge i_clk);
            end
            issue_request(random_request(), 1'b0, tr);
        end
        start <= 1'b0;

        settle = 0;
        while (pending_rsp.size() != 0 && settle < STALL_LIMIT) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (60) @(posedge i_clk);
        if (n_errors == 0 && pending_rsp.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

[first_fit_heap_allocator.f]
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_ram.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/ffha_dp.sv
hw/rtl/first_fit_heap_allocator.sv
hw/rtl/ffha_checker.sv
tb/sv/tb.sv
